### src/fcv_pkg.sv
// ----------------------------------------------------------------------------
// fcv_pkg
// Shared constants, types and helpers for the Fletcher-64 block checksum
// verifier.
// ----------------------------------------------------------------------------
package fcv_pkg;

	localparam int MIN_BLOCK_WORDS = 1024;
	localparam int MAX_BLOCK_WORDS = 16384;

	localparam int POS_W = 15;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	// One finished block as handed from the accumulator to the finisher.
	typedef struct packed {
		logic [63:0] first_sum;
		logic [63:0] second_sum;
		logic [63:0] stored_checksum;
		logic        length_error;
	} block_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	// Second fold of a value already reduced to hi + lo, followed by the
	// complement. An all-ones residue is congruent to zero.
	function automatic logic [31:0] fold_complement(input logic [32:0] a);
		logic [31:0] t;
		t = a[31:0] + {31'b0, a[32]};
		if (t == 32'hFFFF_FFFF) begin
			t = 32'h0;
		end
		return ~t;
	endfunction

endpackage

### src/fcv_front.sv
// ----------------------------------------------------------------------------
// fcv_front
// Accepts block words, captures the stored checksum, runs the two sums and
// hands one record per block to the queue.
// ----------------------------------------------------------------------------
module fcv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [31:0]         s_axis_tdata,  // data_word
	input  logic                s_axis_tlast,  // last_word
	input  fcv_pkg::fifo_status_t q_status,
	output logic                push,
	output fcv_pkg::block_rec_t push_data
);
	import fcv_pkg::*;

	logic [63:0]      first_sum_q;
	logic [63:0]      second_sum_q;
	logic [63:0]      stored_q;
	logic [POS_W-1:0] pos_q;

	logic [63:0] first_sum_n;
	logic [63:0] second_sum_n;
	logic [63:0] stored_n;
	logic        accept;
	logic        is_head;

	assign s_axis_tready = !q_status.full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_head       = (pos_q == '0) || (pos_q == POS_W'(1));

	always_comb begin
		first_sum_n  = first_sum_q;
		second_sum_n = second_sum_q;
		stored_n     = stored_q;
		if (pos_q == '0) begin
			stored_n = {32'b0, s_axis_tdata};
		end else if (pos_q == POS_W'(1)) begin
			stored_n = {s_axis_tdata, stored_q[31:0]};
		end
		if (!is_head) begin
			first_sum_n  = first_sum_q + {32'b0, s_axis_tdata};
			second_sum_n = second_sum_q + first_sum_q + {32'b0, s_axis_tdata};
		end
	end

	always_comb begin
		push                      = accept && s_axis_tlast;
		push_data.first_sum       = first_sum_n;
		push_data.second_sum      = second_sum_n;
		push_data.stored_checksum = stored_n;
		// The count is pos_q + 1, so the bounds move down by one.
		push_data.length_error    = (pos_q < POS_W'(MIN_BLOCK_WORDS - 1)) ||
		                            (pos_q > POS_W'(MAX_BLOCK_WORDS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sum_q  <= '0;
			second_sum_q <= '0;
			stored_q     <= '0;
			pos_q        <= '0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				first_sum_q  <= '0;
				second_sum_q <= '0;
				stored_q     <= '0;
				pos_q        <= '0;
			end else begin
				first_sum_q  <= first_sum_n;
				second_sum_q <= second_sum_n;
				stored_q     <= stored_n;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tlast) |=> (pos_q == '0 && first_sum_q == '0))
		else $error("position or sums not cleared after the last word");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == POS_MAX && accept && !s_axis_tlast) |=> (pos_q == POS_MAX))
		else $error("word position left saturation");

endmodule

### src/fcv_fifo.sv
// ----------------------------------------------------------------------------
// fcv_fifo
// Short queue of block records between the accumulator and the finisher.
// ----------------------------------------------------------------------------
module fcv_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fcv_pkg::block_rec_t   push_data,
	input  logic                  pop,
	output fcv_pkg::block_rec_t   pop_data,
	output fcv_pkg::fifo_status_t status
);
	import fcv_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(FIFO_DEPTH - 1);

	block_rec_t       entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (cnt_q == DEPTH_C);
	assign status.empty = (cnt_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full))
		else $error("record pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty))
		else $error("record popped from an empty queue");

endmodule

### src/fcv_finish.sv
// ----------------------------------------------------------------------------
// fcv_finish
// Pipelined finishing of the Fletcher-64 sums, stored checksum compare and
// result output register.
// ----------------------------------------------------------------------------
module fcv_finish (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fcv_pkg::fifo_status_t q_status,
	input  fcv_pkg::block_rec_t   pop_data,
	output logic                  pop,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [63:0]           m_axis_tdata,  // computed_checksum
	output logic [1:0]            m_axis_tuser   // checksum_match, length_error
);
	import fcv_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [63:0] t_s1;
	logic [63:0] fs_s1, fs_s2, fs_s3;
	logic [63:0] st_s1, st_s2, st_s3;
	logic        le_s1, le_s2, le_s3, le_s4, le_s5, le_s6;
	logic [32:0] a_s2;
	logic [31:0] c1_s3, c1_s4, c1_s5;
	logic [63:0] u_s4;
	logic        lo_ok_s4, lo_ok_s5;
	logic [31:0] st_hi_s4, st_hi_s5;
	logic [32:0] b_s5;
	logic [63:0] result_s6;
	logic        match_s6;
	logic        advance;
	logic [31:0] c2;

	// The whole pipeline moves together and holds while the result waits.
	assign advance = !v_s6 || m_axis_tready;
	assign pop     = advance && !q_status.empty;
	assign c2      = fold_complement(b_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (advance) begin
			v_s1 <= !q_status.empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			t_s1  <= pop_data.second_sum + pop_data.first_sum;
			fs_s1 <= pop_data.first_sum;
			st_s1 <= pop_data.stored_checksum;
			le_s1 <= pop_data.length_error;

			// Since 2^32 is congruent to one, hi + lo keeps the residue.
			a_s2  <= {1'b0, t_s1[63:32]} + {1'b0, t_s1[31:0]};
			fs_s2 <= fs_s1;
			st_s2 <= st_s1;
			le_s2 <= le_s1;

			c1_s3 <= fold_complement(a_s2);
			fs_s3 <= fs_s2;
			st_s3 <= st_s2;
			le_s3 <= le_s2;

			u_s4     <= fs_s3 + {32'b0, c1_s3};
			c1_s4    <= c1_s3;
			lo_ok_s4 <= (c1_s3 == st_s3[31:0]);
			st_hi_s4 <= st_s3[63:32];
			le_s4    <= le_s3;

			b_s5     <= {1'b0, u_s4[63:32]} + {1'b0, u_s4[31:0]};
			c1_s5    <= c1_s4;
			lo_ok_s5 <= lo_ok_s4;
			st_hi_s5 <= st_hi_s4;
			le_s5    <= le_s4;

			result_s6 <= {c2, c1_s5};
			match_s6  <= lo_ok_s5 && (c2 == st_hi_s5);
			le_s6     <= le_s5;
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = result_s6;
	assign m_axis_tuser  = {le_s6, match_s6};

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped record did not enter the pipeline");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && v_s6 && !m_axis_tready) |=> v_s5)
		else $error("pipeline advanced under a stalled output");

endmodule

### src/fletcher64_block_checksum_verify_top.sv
// Path: a block's record passes the queue, then finishing stages s1 to s6.
// Throughput: one word per cycle while the 4-entry queue is not full; each
// block yields one result, and the finishing pipeline takes a new block
// every cycle while its output is not stalled.
// Reset: arst_n clears the sums, word position, queue and pipeline valids.
// ----------------------------------------------------------------------------
// fletcher64_block_checksum_verify_top
// Fletcher-64 checksum check of a storage block given as a word stream.
// ----------------------------------------------------------------------------
module fletcher64_block_checksum_verify_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // data_word
	input  logic        s_axis_tlast,   // last_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // computed_checksum
	output logic [1:0]  m_axis_tuser    // checksum_match, length_error
);
	import fcv_pkg::*;

	fifo_status_t q_status;
	block_rec_t   push_data;
	block_rec_t   pop_data;
	logic         push;
	logic         pop;

	fcv_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_status      (q_status),
		.push          (push),
		.push_data     (push_data)
	);

	fcv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	fcv_finish u_finish (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.pop_data      (pop_data),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

### tb/fletcher64_block_checksum_verify_top_tb.sv
// ----------------------------------------------------------------------------
// fletcher64_block_checksum_verify_top_tb
// Self-checking bench for the Fletcher-64 block checksum verifier. Blocks
// range from a single word up to the smallest legal block size. Their stored
// checksums are correct, corrupted or unsealed. They are streamed with random
// source gaps and sink stalls. A bench-side copy of the running sums predicts
// every result, and each field is compared in order.
// ----------------------------------------------------------------------------
module fletcher64_block_checksum_verify_top_tb;

	localparam logic [63:0] FOLD_MOD     = 64'h0000_0000_FFFF_FFFF;
	localparam int          IDLE_LIMIT   = 2000;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          RAND_WORDS   = 760;
	localparam int          RAND_BLOCKS  = 30;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
	typedef enum int {SEAL_NONE, SEAL_GOOD, SEAL_FLIPPED} seal_t;

	typedef struct packed {
		logic [31:0] data;
		logic        last;
	} word_xfer_t;

	typedef struct packed {
		logic [63:0] checksum;
		logic        match;
		logic        len_err;
	} block_verdict_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	word_xfer_t     word_backlog[$];
	block_verdict_t pending_verdicts[$];

	// Bench copy of the block state.
	logic [63:0] sum_words;
	logic [63:0] sum_of_sums;
	logic [63:0] stored_csum;
	logic [14:0] word_idx;

	block_verdict_t predicted;
	block_verdict_t observed;
	word_xfer_t     next_word;
	int             block_len;
	int             errors       = 0;
	int             words_seen   = 0;
	int             blocks_seen  = 0;
	int             matches_seen = 0;
	int             len_errs_seen = 0;
	int             send_gap     = 0;
	int             send_burst   = 0;
	int             stall_left   = 0;
	int             recv_burst   = 0;
	int             idle_cycles  = 0;

	fletcher64_block_checksum_verify_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Reduce modulo 2^32 - 1 and complement in 32 bits.
	function automatic logic [31:0] fold_inv(input logic [63:0] v);
		logic [63:0] r;
		r = v % FOLD_MOD;
		return ~r[31:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_block(input int unsigned n_words, input fill_t fill, input seal_t seal);
		logic [31:0] words[$];
		logic [31:0] w;
		logic [63:0] s1;
		logic [63:0] s2;
		logic [31:0] c1;
		int          pos;
		s1 = '0;
		s2 = '0;
		for (int i = 0; i < n_words; i++) begin
			case (fill)
				FILL_ZERO: w = '0;
				FILL_ONES: w = '1;
				default:   w = $urandom;
			endcase
			words.push_back(w);
			if (i >= 2) begin
				s1 += {32'b0, w};
				s2 += s1;
			end
		end
		if (seal != SEAL_NONE && n_words >= 2) begin
			c1 = fold_inv(s2 + s1);
			words[0] = c1;
			words[1] = fold_inv(s1 + {32'b0, c1});
		end
		if (seal == SEAL_FLIPPED) begin
			pos = $urandom_range(0, n_words - 1);
			words[pos][$urandom_range(0, 31)] ^= 1'b1;
		end
		for (int i = 0; i < n_words; i++)
			word_backlog.push_back('{data: words[i], last: (i == n_words - 1)});
	endtask

	// Source side: the next word is presented once the current one has
	// transferred and the chosen gap has run out.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
			send_gap = 0;
			send_burst = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (word_backlog.size() != 0) begin
				next_word = word_backlog.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= next_word.data;
				s_axis_tlast  <= next_word.last;
				if (send_burst > 0)
					send_burst--;
				else if ($urandom_range(0, 99) < 2)
					send_burst = $urandom_range(100, 600);
				else
					send_gap = pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Sink side: random stalls, with occasional stretches of constant ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
			recv_burst = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (recv_burst > 0)
				recv_burst--;
			else if ($urandom_range(0, 99) < 2)
				recv_burst = $urandom_range(100, 600);
			else if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// Result check first, then prediction from the word accepted at this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_words   = '0;
			sum_of_sums = '0;
			stored_csum = '0;
			word_idx    = '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				observed = '{checksum: m_axis_tdata, match: m_axis_tuser[0],
					len_err: m_axis_tuser[1]};
				if (pending_verdicts.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, checksum %h match %b length error %b",
						$time, observed.checksum, observed.match, observed.len_err);
				end else begin
					predicted = pending_verdicts.pop_front();
					if (observed.checksum !== predicted.checksum) begin
						errors++;
						$display("%0t: checksum mismatch, expected %h actual %h",
							$time, predicted.checksum, observed.checksum);
					end
					if (observed.match !== predicted.match) begin
						errors++;
						$display("%0t: match flag mismatch, expected %b actual %b",
							$time, predicted.match, observed.match);
					end
					if (observed.len_err !== predicted.len_err) begin
						errors++;
						$display("%0t: length error mismatch, expected %b actual %b",
							$time, predicted.len_err, observed.len_err);
					end
				end
				matches_seen  += observed.match;
				len_errs_seen += observed.len_err;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				words_seen++;
				if (word_idx == '0) begin
					stored_csum = {32'b0, s_axis_tdata};
				end else if (word_idx == 15'd1) begin
					stored_csum = {s_axis_tdata, stored_csum[31:0]};
				end else begin
					sum_words   = sum_words + {32'b0, s_axis_tdata};
					sum_of_sums = sum_of_sums + sum_words;
				end
				block_len = int'(word_idx) + 1;
				// The position counter sticks at its top value on overlong blocks.
				if (word_idx != fcv_pkg::POS_MAX)
					word_idx = word_idx + 15'd1;
				if (s_axis_tlast) begin
					predicted.checksum[31:0]  = fold_inv(sum_of_sums + sum_words);
					predicted.checksum[63:32] = fold_inv(sum_words
						+ {32'b0, predicted.checksum[31:0]});
					predicted.match   = (predicted.checksum == stored_csum);
					predicted.len_err = (block_len < fcv_pkg::MIN_BLOCK_WORDS)
						|| (block_len > fcv_pkg::MAX_BLOCK_WORDS);
					pending_verdicts.push_back(predicted);
					blocks_seen++;
					sum_words   = '0;
					sum_of_sums = '0;
					stored_csum = '0;
					word_idx    = '0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, IDLE_LIMIT, pending_verdicts.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned rand_words;
		int unsigned rand_blocks;
		int unsigned len;
		int          r;

		// Directed blocks: one too short to hold a checksum, one that holds only
		// a checksum, a zero fill, and one block of the smallest legal size.
		queue_block(1, FILL_RANDOM, SEAL_NONE);
		queue_block(2, FILL_RANDOM, SEAL_GOOD);
		queue_block(3, FILL_ZERO, SEAL_GOOD);
		queue_block(fcv_pkg::MIN_BLOCK_WORDS, FILL_RANDOM, SEAL_GOOD);

		rand_words  = 0;
		rand_blocks = 0;
		while (rand_words < RAND_WORDS || rand_blocks < RAND_BLOCKS) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				len = $urandom_range(2, 40);
				queue_block(len, FILL_RANDOM, SEAL_GOOD);
			end else if (r < 55) begin
				len = $urandom_range(1, 16);
				queue_block(len, ($urandom_range(0, 1) != 0) ? FILL_ONES : FILL_ZERO,
					($urandom_range(0, 1) != 0) ? SEAL_GOOD : SEAL_NONE);
			end else begin
				len = $urandom_range(1, 48);
				queue_block(len, FILL_RANDOM,
					($urandom_range(0, 1) != 0) ? SEAL_NONE : SEAL_FLIPPED);
			end
			rand_words  += len;
			rand_blocks++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (word_backlog.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d blocks in %0d words under random gaps and stalls.",
			blocks_seen, words_seen);
		$display("Results seen: %0d checksum matches, %0d length errors, %0d mismatches.",
			matches_seen, len_errs_seen, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
